[rtl/bffa_pkg.sv]
// types, constants and helpers shared by the bitmap first-free allocator
`timescale 1ns / 1ps
`default_nettype none

package bffa_pkg;

  // map geometry
  localparam int MAP_BYTES   = 1024;
  localparam int INDEX_LIMIT = 8192;
  localparam int MAP_BITS    = MAP_BYTES * 8;
  localparam int MAP_CAP     = (MAP_BITS < INDEX_LIMIT) ? MAP_BITS : INDEX_LIMIT;

  // field widths
  localparam int CMD_W     = 2;
  localparam int IDX_W     = 13;
  localparam int CNT_W     = 14;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 14;

  // storage word
  localparam int WORD_W    = 64;
  localparam int OFF_W     = 6;
  localparam int NUM_WORDS = (MAP_CAP + WORD_W - 1) / WORD_W;
  localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(NUM_WORDS - 1);
  localparam logic [CNT_W-1:0]   CAP_CNT   = CNT_W'(MAP_CAP);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ALLOWED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BITS_IN_USE   = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC     = 2'd0,
    CMD_MARK_USED = 2'd1,
    CMD_MARK_FREE = 2'd2,
    CMD_TEST      = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MODIFY,
    S_DONE
  } state_e;

  // bounds applied to one word during the scan
  typedef struct packed {
    logic [OFF_W-1:0] lo_off;
    logic [OFF_W-1:0] hi_off;
  } scan_win_t;

  typedef struct packed {
    logic             found;
    logic [OFF_W-1:0] pos;
  } scan_res_t;

  function automatic logic [WADDR_W-1:0] word_of(input logic [IDX_W-1:0] idx);
    return WADDR_W'(idx >> OFF_W);
  endfunction

endpackage

`default_nettype wire

[rtl/bffa_if.sv]
// command and response channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface bffa_cmd_if;
  import bffa_pkg::*;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [IDX_W-1:0] entry_index;

  modport source (output valid, output cmd, output entry_index, input ready);
  modport sink   (input valid, input cmd, input entry_index, output ready);
endinterface

interface bffa_rsp_if;
  import bffa_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [IDX_W-1:0]    result_index;
  logic                prior_bit;
  logic [CNT_W-1:0]    free_left;

  modport source (output valid, output status, output result_index, output prior_bit,
                  output free_left, input ready);
  modport sink   (input valid, input status, input result_index, input prior_bit,
                  input free_left, output ready);
endinterface

`default_nettype wire

[rtl/bffa_map_ram.sv]
// usage map storage, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module bffa_map_ram (
  input  wire logic                         clk_i,
  input  wire logic                         we_i,
  input  wire logic [bffa_pkg::WADDR_W-1:0] waddr_i,
  input  wire logic [bffa_pkg::WORD_W-1:0]  wdata_i,
  input  wire logic [bffa_pkg::WADDR_W-1:0] raddr_i,
  output logic      [bffa_pkg::WORD_W-1:0]  rdata_o
);
  import bffa_pkg::*;

  logic [WORD_W-1:0] mem [NUM_WORDS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/bffa_word_scan.sv]
// lowest clear bit of one map word inside a window
`timescale 1ns / 1ps
`default_nettype none

module bffa_word_scan (
  input  wire logic [bffa_pkg::WORD_W-1:0] word_i,
  input  wire bffa_pkg::scan_win_t         win_i,
  output bffa_pkg::scan_res_t              res_o
);
  import bffa_pkg::*;

  logic [WORD_W-1:0] lo_mask;
  logic [WORD_W-1:0] hi_mask;
  logic [WORD_W-1:0] cand;

  always_comb begin
    lo_mask   = {WORD_W{1'b1}} << win_i.lo_off;
    hi_mask   = {WORD_W{1'b1}} >> (OFF_W'(WORD_W - 1) - win_i.hi_off);
    cand      = ~word_i & lo_mask & hi_mask;
    res_o.found = |cand;
    res_o.pos   = '0;
    // priority encoder, lowest set bit wins
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        res_o.pos = OFF_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/bitmap_first_free_allocator_unit.sv]
// bitmap first-free allocator: sequencer, counters and response register
//
//   channel   dir  handshake              payload
//   cmd_i     in   valid / ready          cmd, entry_index
//   rsp_o     out  valid / ready          status, result_index, prior_bit, free_left
//   cfg       in   cfg_we_i, no stall     cfg_idx_i, cfg_wdata_i
//
// allocate: scans the 64-bit map words in turn from the start word, at most NUM_WORDS
//   of them (128 with 1024 map bytes); one ram read port sets the pace
// mark / test: read, modify-write, response; out of range goes straight to the response
// reset and every bits_in_use write sweep the map to zero, one word a cycle,
//   all NUM_WORDS words (128), with cmd ready low meanwhile
// a pending response word waits in its own register, so the next command is
//   taken while it is stalled; a finished result waits in S_DONE if that register is full
`timescale 1ns / 1ps
`default_nettype none

module bitmap_first_free_allocator_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  bffa_cmd_if.sink                            cmd_i,
  bffa_rsp_if.source                          rsp_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [bffa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [bffa_pkg::CFG_DAT_W-1:0] cfg_wdata_i
);
  import bffa_pkg::*;

  // control state
  state_e               state_q, state_d;
  logic [WADDR_W-1:0]   clr_q, clr_d;
  logic [IDX_W-1:0]     fa_q, fa_d;
  logic [CNT_W-1:0]     size_q, size_d;
  logic [CNT_W-1:0]     free_q, free_d;
  logic                 out_valid_q, out_valid_d;

  // per-command payload
  logic [WADDR_W-1:0]   cur_q, cur_d;
  cmd_e                 cmd_q, cmd_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  status_e              res_status_q, res_status_d;
  logic [IDX_W-1:0]     res_index_q, res_index_d;
  logic                 res_prior_q, res_prior_d;
  status_e              out_status_q, out_status_d;
  logic [IDX_W-1:0]     out_index_q, out_index_d;
  logic                 out_prior_q, out_prior_d;
  logic [CNT_W-1:0]     out_free_q, out_free_d;

  // map ram
  logic                 ram_we;
  logic [WADDR_W-1:0]   ram_waddr;
  logic [WORD_W-1:0]    ram_wdata;
  logic [WADDR_W-1:0]   ram_raddr;
  logic [WORD_W-1:0]    ram_rdata;

  // scan window
  scan_win_t            win;
  scan_res_t            scan;
  logic [CNT_W-1:0]     size_m1;
  logic [WADDR_W-1:0]   start_word;
  logic [WADDR_W-1:0]   last_word;
  logic [WORD_W-1:0]    bit_sel;
  logic                 prior;
  cmd_e                 cmd_in;
  logic [CNT_W-1:0]     new_size;

  bffa_map_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bffa_word_scan u_scan (
    .word_i (ram_rdata),
    .win_i  (win),
    .res_o  (scan)
  );

  assign size_m1    = size_q - CNT_W'(1);
  assign start_word = word_of(fa_q);
  assign last_word  = WADDR_W'(size_m1 >> OFF_W);
  assign cmd_in     = cmd_e'(cmd_i.cmd);
  assign new_size   = (cfg_wdata_i > CAP_CNT) ? CAP_CNT : cfg_wdata_i;

  // window bounds only bite on the first and last word of the scan
  always_comb begin
    win.lo_off = (cur_q == start_word) ? fa_q[OFF_W-1:0] : '0;
    win.hi_off = (cur_q == last_word) ? size_m1[OFF_W-1:0] : '1;
  end

  assign bit_sel = WORD_W'(1) << idx_q[OFF_W-1:0];
  assign prior   = ram_rdata[idx_q[OFF_W-1:0]];

  assign cmd_i.ready        = (state_q == S_IDLE);
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.result_index = out_index_q;
  assign rsp_o.prior_bit    = out_prior_q;
  assign rsp_o.free_left    = out_free_q;

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    fa_d         = fa_q;
    size_d       = size_q;
    free_d       = free_q;
    cur_d        = cur_q;
    cmd_d        = cmd_q;
    idx_d        = idx_q;
    res_status_d = res_status_q;
    res_index_d  = res_index_q;
    res_prior_d  = res_prior_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_index_d  = out_index_q;
    out_prior_d  = out_prior_q;
    out_free_d   = out_free_q;
    ram_we       = 1'b0;
    ram_waddr    = cur_q;
    ram_wdata    = '0;
    ram_raddr    = cur_q + WADDR_W'(1);

    // response word leaves
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        if (clr_q == LAST_WORD) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + WADDR_W'(1);
        end
      end
      S_IDLE: begin
        if (cmd_i.valid) begin
          cmd_d = cmd_in;
          idx_d = cmd_i.entry_index;
          if (cmd_in == CMD_ALLOC) begin
            if ({1'b0, fa_q} >= size_q) begin
              res_status_d = STAT_FULL;
              res_index_d  = '0;
              res_prior_d  = 1'b0;
              state_d      = S_DONE;
            end else begin
              ram_raddr = start_word;
              cur_d     = start_word;
              state_d   = S_SCAN;
            end
          end else if ({1'b0, cmd_i.entry_index} >= size_q) begin
            res_status_d = STAT_RANGE;
            res_index_d  = cmd_i.entry_index;
            res_prior_d  = 1'b0;
            state_d      = S_DONE;
          end else begin
            ram_raddr = word_of(cmd_i.entry_index);
            state_d   = S_MODIFY;
          end
        end
      end
      S_SCAN: begin
        // word cur_q is on the read port, next word is being fetched
        if (scan.found) begin
          ram_we       = 1'b1;
          ram_waddr    = cur_q;
          ram_wdata    = ram_rdata | (WORD_W'(1) << scan.pos);
          if (free_q != '0) begin
            free_d = free_q - CNT_W'(1);
          end
          res_status_d = STAT_OK;
          res_index_d  = IDX_W'({cur_q, scan.pos});
          res_prior_d  = 1'b0;
          state_d      = S_DONE;
        end else if (cur_q == last_word) begin
          res_status_d = STAT_FULL;
          res_index_d  = '0;
          res_prior_d  = 1'b0;
          state_d      = S_DONE;
        end else begin
          cur_d = cur_q + WADDR_W'(1);
        end
      end
      S_MODIFY: begin
        ram_waddr    = word_of(idx_q);
        res_status_d = STAT_OK;
        res_index_d  = idx_q;
        res_prior_d  = prior;
        if (cmd_q == CMD_MARK_USED && !prior) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata | bit_sel;
          if (free_q != '0) begin
            free_d = free_q - CNT_W'(1);
          end
        end else if (cmd_q == CMD_MARK_FREE && prior) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata & ~bit_sel;
          free_d    = free_q + CNT_W'(1);
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_index_d  = res_index_q;
          out_prior_d  = res_prior_q;
          out_free_d   = free_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // register writes: the user must write only while idle; the block itself does not enforce it
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FIRST_ALLOWED: begin
          fa_d = cfg_wdata_i[IDX_W-1:0];
        end
        CFG_BITS_IN_USE: begin
          // new size: map swept to zero, every entry free
          size_d  = new_size;
          free_d  = new_size;
          clr_d   = '0;
          state_d = S_CLEAR;
        end
        default: begin
          fa_d = fa_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      fa_q        <= '0;
      size_q      <= CAP_CNT;
      free_q      <= CAP_CNT;
      out_valid_q <= 1'b0;
    end else begin
      clr_q       <= clr_d;
      fa_q        <= fa_d;
      size_q      <= size_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    cmd_q        <= cmd_d;
    idx_q        <= idx_d;
    res_status_q <= res_status_d;
    res_index_q  <= res_index_d;
    res_prior_q  <= res_prior_d;
    out_status_q <= out_status_d;
    out_index_q  <= out_index_d;
    out_prior_q  <= out_prior_d;
    out_free_q   <= out_free_d;
  end

endmodule

`default_nettype wire

[rtl/bffa_checker.sv]
// port-level assertions for the allocator and their bind
`timescale 1ns / 1ps
`default_nettype none

module bffa_port_props (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_i,
  input wire logic                          out_valid_i,
  input wire logic                          out_ready_i,
  input wire logic [bffa_pkg::STATUS_W-1:0] out_status_i,
  input wire logic [bffa_pkg::IDX_W-1:0]    out_index_i,
  input wire logic                          out_prior_i,
  input wire logic [bffa_pkg::CNT_W-1:0]    out_free_i
);
  import bffa_pkg::*;

  // a stalled response word stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("response dropped while stalled");

  // one command at a time
  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("command taken while busy");

  // full never shows an index or a prior bit
  a_full_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == STAT_FULL |-> out_index_i == '0 && !out_prior_i)
    else $error("full response carries data");

  // out of range never reads the map
  a_range_prior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == STAT_RANGE |-> !out_prior_i)
    else $error("range response carries prior bit");

  // free count stays within the map
  a_free_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_free_i <= CAP_CNT)
    else $error("free count beyond map size");

endmodule

bind bitmap_first_free_allocator_unit bffa_port_props u_bffa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (cmd_i.valid),
  .in_ready_i   (cmd_i.ready),
  .out_valid_i  (rsp_o.valid),
  .out_ready_i  (rsp_o.ready),
  .out_status_i (rsp_o.status),
  .out_index_i  (rsp_o.result_index),
  .out_prior_i  (rsp_o.prior_bit),
  .out_free_i   (rsp_o.free_left)
);

`default_nettype wire

[test/bffa_checker.sv]
// checker for the bitmap first-free allocator: predicts every response word and compares it
`timescale 1ns / 1ps

module bffa_checker
  import bffa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  bffa_cmd_if                  cmd_i,
  bffa_rsp_if                  rsp_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i,
  output int                   pending_o,
  output int                   errors_o
);

  typedef struct {
    status_e          st;
    logic [IDX_W-1:0] idx;
    logic             prior;
    logic [CNT_W-1:0] free;
  } alloc_reply_t;

  // shadow copy of the allocator state
  logic [MAP_CAP-1:0] used_bits;
  logic [CNT_W-1:0]   free_cnt;
  logic [IDX_W-1:0]   first_ok;
  logic [CNT_W-1:0]   bits_used;

  alloc_reply_t reply_q[$];
  int           err_cnt;
  bit           word_bad;

  assign errors_o = err_cnt;

  function automatic int span_of(input logic [CNT_W-1:0] n);
    return (int'(n) > MAP_CAP) ? MAP_CAP : int'(n);
  endfunction

  task automatic predict_reply(input cmd_e c, input logic [IDX_W-1:0] ix,
                               output alloc_reply_t r);
    int sz;
    int hit;
    bit found;
    sz = span_of(bits_used);
    r.st = STAT_OK;
    r.idx = ix;
    r.prior = 1'b0;
    if (c == CMD_ALLOC) begin
      found = 1'b0;
      hit = 0;
      for (int k = int'(first_ok); k < sz && !found; k++) begin
        if (!used_bits[k]) begin
          found = 1'b1;
          hit = k;
        end
      end
      r.idx = '0;
      if (found) begin
        used_bits[hit] = 1'b1;
        if (free_cnt != '0) free_cnt = free_cnt - CNT_W'(1);
        r.idx = IDX_W'(hit);
      end else begin
        r.st = STAT_FULL;
      end
    end else if (int'(ix) >= sz) begin
      r.st = STAT_RANGE;
    end else begin
      r.prior = used_bits[ix];
      if (c == CMD_MARK_USED && !r.prior) begin
        used_bits[ix] = 1'b1;
        if (free_cnt != '0) free_cnt = free_cnt - CNT_W'(1);
      end else if (c == CMD_MARK_FREE && r.prior) begin
        used_bits[ix] = 1'b0;
        free_cnt = free_cnt + CNT_W'(1);
      end
    end
    r.free = free_cnt;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      word_bad = 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_reply_t r;
    if (!rst_ni) begin
      used_bits = '0;
      first_ok  = '0;
      bits_used = CNT_W'(INDEX_LIMIT);
      free_cnt  = CNT_W'(span_of(bits_used));
      reply_q.delete();
      err_cnt   = 0;
      pending_o <= 0;
    end else begin
      // register writes land with no command in flight
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FIRST_ALLOWED: begin
            first_ok = cfg_wdata_i[IDX_W-1:0];
          end
          CFG_BITS_IN_USE: begin
            bits_used = cfg_wdata_i;
            used_bits = '0;
            free_cnt  = CNT_W'(span_of(bits_used));
          end
          default: ;
        endcase
      end
      // response first: a word taken on this edge belongs to an older command
      if (rsp_i.valid && rsp_i.ready) begin
        if (reply_q.size() == 0) begin
          $display("%0t: response with none expected, got status %0d idx %0d prior %0d free %0d",
                   $time, rsp_i.status, rsp_i.result_index, rsp_i.prior_bit, rsp_i.free_left);
          err_cnt++;
        end else begin
          r = reply_q.pop_front();
          word_bad = 1'b0;
          check_field("status", int'(r.st), int'(rsp_i.status));
          check_field("result_index", int'(r.idx), int'(rsp_i.result_index));
          check_field("prior_bit", int'(r.prior), int'(rsp_i.prior_bit));
          check_field("free_left", int'(r.free), int'(rsp_i.free_left));
          if (word_bad) err_cnt++;
        end
      end
      if (cmd_i.valid && cmd_i.ready) begin
        predict_reply(cmd_e'(cmd_i.cmd), cmd_i.entry_index, r);
        reply_q.push_back(r);
      end
      pending_o <= reply_q.size();
    end
  end

endmodule

[test/tb_bitmap_first_free_allocator_unit.sv]
// testbench top for the bitmap first-free allocator: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_bitmap_first_free_allocator_unit;
  import bffa_pkg::*;

  localparam int RESET_CYCLES = 11;
  localparam int STALL_LIMIT  = 4000;  // cycles with no word moving on either channel
  localparam int LONG_HOLD    = 400;   // receiver hold-off that backs the block up
  localparam int TAIL_CYCLES  = 200;   // beyond the worst allocate scan
  localparam int NUM_PHASES   = 12;
  localparam int PHASE_WORDS  = 145;
  localparam int KEEP_SIZE    = -2;    // leave bits_in_use alone, map survives
  localparam int PICK_RANDOM  = -1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // config port
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  bffa_cmd_if cmd_bus ();
  bffa_rsp_if rsp_bus ();

  int pending;
  int err_cnt;

  // flow control knobs, percent of cycles spent idle
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_toggle = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;

  // stimulus-side view of the setting, only used to aim indexes and first_allowed
  int cur_first = 0;
  int cur_size  = INDEX_LIMIT;

  int idle_run = 0;

  always #1 clk = ~clk;

  bitmap_first_free_allocator_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cmd_i       (cmd_bus),
    .rsp_o       (rsp_bus),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  bffa_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cmd_i       (cmd_bus),
    .rsp_i       (rsp_bus),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .pending_o   (pending),
    .errors_o    (err_cnt)
  );

  // response side: random ready, or a long hold-off when the toggle flips
  always @(posedge clk) begin
    if (hold_seen != hold_toggle) begin
      hold_seen <= hold_toggle;
      hold_left <= LONG_HOLD;
      rsp_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // watchdog: a hang shows up as a long run with no word moving
  always @(posedge clk) begin
    if ((cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
      if (idle_run >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // offer one command word, with a random gap in front of it
  task automatic send_word(input cmd_e c, input logic [IDX_W-1:0] ix);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_bus.valid       <= 1'b1;
    cmd_bus.cmd         <= c;
    cmd_bus.entry_index <= ix;
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
  endtask

  // stop sending and wait for every expected response word
  task automatic drain();
    cmd_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] ri, input int val);
    cfg_we    <= 1'b1;
    cfg_idx   <= ri;
    cfg_wdata <= CFG_DAT_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (ri == CFG_FIRST_ALLOWED) begin
      cur_first = val & (INDEX_LIMIT - 1);
    end else begin
      cur_size = ((val & 16'h3fff) > MAP_CAP) ? MAP_CAP : (val & 16'h3fff);
    end
  endtask

  // indexes lean toward the region around first_allowed, where allocations pile up
  function automatic logic [IDX_W-1:0] pick_entry();
    int r;
    int lo;
    int hi;
    r = $urandom_range(0, 99);
    if (cur_size == 0 || r < 15) return IDX_W'($urandom_range(0, INDEX_LIMIT - 1));
    if (r < 40) return IDX_W'($urandom_range(0, cur_size - 1));
    lo = (cur_first < cur_size) ? cur_first : 0;
    hi = (lo + 63 < cur_size - 1) ? lo + 63 : cur_size - 1;
    return IDX_W'($urandom_range(lo, hi));
  endfunction

  function automatic cmd_e pick_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return CMD_ALLOC;
    if (r < 60) return CMD_MARK_USED;
    if (r < 85) return CMD_MARK_FREE;
    return CMD_TEST;
  endfunction

  // one setting of the registers, then a run of random words under it
  task automatic run_phase(input int p, input int fa, input int biu, input int words);
    int mode;
    if (biu == PICK_RANDOM) biu = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 16383)
                                                               : $urandom_range(1, 200);
    if (biu != KEEP_SIZE) write_reg(CFG_BITS_IN_USE, biu);
    if (fa == PICK_RANDOM) fa = $urandom_range(0, cur_size + 4);
    // bit 13 of the data is dropped by a 13-bit register
    write_reg(CFG_FIRST_ALLOWED, fa | ($urandom_range(0, 1) << IDX_W));
    mode = p * 3 / NUM_PHASES;
    case (mode)
      0: begin
        send_idle_pct <= 18;
        recv_idle_pct <= 73;
      end
      1: begin
        send_idle_pct <= 73;
        recv_idle_pct <= 18;
      end
      default: begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
    endcase
    for (int n = 0; n < words; n++) begin
      // one long receiver hold-off while commands keep coming
      if (p == 1 && n == 20) hold_toggle <= ~hold_toggle;
      send_word(pick_cmd(), pick_entry());
    end
    drain();
  endtask

  int ph_fa  [NUM_PHASES] = '{0, 0, 5, 0, 8191, 30, 12, 0, 100, PICK_RANDOM, 1000,
                              PICK_RANDOM};
  int ph_biu [NUM_PHASES] = '{8192, 16383, 24, 1, 8192, 32, KEEP_SIZE, 0, 300,
                              PICK_RANDOM, 1100, PICK_RANDOM};

  initial begin
    cmd_bus.valid       = 1'b0;
    cmd_bus.cmd         = CMD_ALLOC;
    cmd_bus.entry_index = '0;
    rsp_bus.ready       = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: default setting, extremes of the index, repeat marks
    send_word(CMD_ALLOC, '0);
    send_word(CMD_ALLOC, 13'h1fff);
    send_word(CMD_TEST, '0);
    send_word(CMD_TEST, 13'h1fff);
    send_word(CMD_MARK_USED, 13'h1fff);
    send_word(CMD_MARK_USED, 13'h1fff);   // already used
    send_word(CMD_MARK_FREE, 13'h1fff);
    send_word(CMD_MARK_FREE, 13'h1fff);   // already free
    send_word(CMD_MARK_FREE, '0);
    send_word(CMD_ALLOC, '0);             // freed entry comes back first
    send_word(CMD_TEST, 13'd1);
    send_word(CMD_MARK_FREE, 13'd1);
    drain();

    // zero bits in use: everything out of range or full
    write_reg(CFG_BITS_IN_USE, 0);
    send_word(CMD_ALLOC, '0);
    send_word(CMD_TEST, '0);
    send_word(CMD_MARK_USED, 13'h1fff);
    send_word(CMD_MARK_FREE, '0);
    drain();

    // start at the top entry, then start past the size
    write_reg(CFG_BITS_IN_USE, INDEX_LIMIT);
    write_reg(CFG_FIRST_ALLOWED, 16383);
    send_word(CMD_ALLOC, '0);
    send_word(CMD_ALLOC, '0);             // nothing left above the start
    send_word(CMD_TEST, 13'h1fff);
    drain();
    write_reg(CFG_BITS_IN_USE, 100);
    write_reg(CFG_FIRST_ALLOWED, 100);
    send_word(CMD_ALLOC, '0);
    send_word(CMD_MARK_USED, 13'd99);
    send_word(CMD_MARK_USED, 13'd100);    // first index past the size
    drain();

    // random phases across settings and flow-control modes
    for (int p = 0; p < NUM_PHASES; p++) begin
      run_phase(p, ph_fa[p], ph_biu[p], (ph_biu[p] == 0) ? 30 : PHASE_WORDS);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
